@@ rtl/core/vks_pkg.sv @@
// Shared types and constants for the vehicle kinematics stream.
`timescale 1ns / 1ps
`default_nettype none
package vks_pkg;

    localparam int XY_W = 35;
    localparam int Z_W = 30;
    localparam int MAX_STEPS = 24;
    localparam logic [23:0] GAIN_Q24 = 24'd10188014;
    localparam logic [16:0] DIV50_RECIP = 17'd83887;
    localparam logic [15:0] SPEED_MAX = 16'd46341;
    localparam logic signed [17:0] HEADING_LIMIT = 18'sd23040;
    localparam logic signed [Z_W-1:0] Z_QUARTER = 30'sd94371840;

    localparam logic [Z_W-1:0] ATAN_TAB [0:MAX_STEPS-1] = '{
        30'd47185920, 30'd27855475, 30'd14718068, 30'd7471121, 30'd3750058,
        30'd1876857, 30'd938658, 30'd469357, 30'd234682, 30'd117342,
        30'd58671, 30'd29335, 30'd14668, 30'd7334, 30'd3667, 30'd1833,
        30'd917, 30'd458, 30'd229, 30'd115, 30'd57, 30'd29, 30'd14, 30'd7
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic signed [15:0]     ego_speed;
        logic signed [15:0]     ego_accel;
        logic                   start;
    } vks_data_t;

endpackage
`default_nettype wire

@@ rtl/core/vehicle_kinematics_stream.sv @@
// Top level: input rotation, chain of CORDIC cells, post stages and output register.
// Throughput: one beat at a time; the next input is taken once the result beat leaves
// the output register, so a stall at the output also holds off the input.
// Reset clears all valid flags, the previous speed and the first-sample flag.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_kinematics_stream #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] long_speed,
    input  logic signed [15:0] lat_speed,
    input  logic signed [15:0] ego_speed,
    input  logic signed [15:0] ego_accel,
    input  logic               series_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        speed,
    output logic signed [15:0] heading,
    output logic signed [10:0] accel,
    output logic signed [17:0] rel_speed,
    output logic signed [16:0] rel_accel
);
    import vks_pkg::*;

    localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    vks_data_t          chain [0:N];
    logic               cvalid [0:N];
    vks_data_t          d0_next;
    vks_data_t          d0_reg;
    logic               v0_reg;
    logic               busy_reg;
    logic               accept;
    logic signed [XY_W-1:0] lx;
    logic signed [XY_W-1:0] ly;

    logic               pv;
    logic [15:0]        p_speed;
    logic signed [15:0] p_heading;
    logic signed [10:0] p_accel;
    logic signed [17:0] p_rel_speed;
    logic signed [16:0] p_rel_accel;
    logic               ov_reg;
    logic [15:0]        speed_reg;
    logic signed [15:0] heading_reg;
    logic signed [10:0] accel_reg;
    logic signed [17:0] rel_speed_reg;
    logic signed [16:0] rel_accel_reg;

    assign accept = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    always_comb
    begin
        lx = {{3{long_speed[15]}}, long_speed, 16'd0};
        ly = {{3{lat_speed[15]}}, lat_speed, 16'd0};
        d0_next.x = lx;
        d0_next.y = ly;
        d0_next.z = '0;
        if (lx[XY_W-1])
        begin
            if (!ly[XY_W-1])
            begin
                d0_next.x = ly;
                d0_next.y = -lx;
                d0_next.z = Z_QUARTER;
            end
            else
            begin
                d0_next.x = -ly;
                d0_next.y = lx;
                d0_next.z = -Z_QUARTER;
            end
        end
        d0_next.zero = (long_speed == 16'sd0) && (lat_speed == 16'sd0);
        d0_next.ego_speed = ego_speed;
        d0_next.ego_accel = ego_accel;
        d0_next.start = series_start;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d0_reg <= d0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            busy_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                busy_reg <= 1'b0;
            end
            if (pv)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign chain[0] = d0_reg;
    assign cvalid[0] = v0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        vks_cell #(
            .STAGE(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .valid_in(cvalid[i]),
            .data_in(chain[i]),
            .valid_out(cvalid[i+1]),
            .data_out(chain[i+1])
        );
    end

    vks_post u_post (
        .clk(clk),
        .rst_n(rst_n),
        .valid_in(cvalid[N]),
        .data_in(chain[N]),
        .valid_out(pv),
        .speed(p_speed),
        .heading(p_heading),
        .accel(p_accel),
        .rel_speed(p_rel_speed),
        .rel_accel(p_rel_accel)
    );

    always_ff @(posedge clk)
    begin
        if (pv)
        begin
            speed_reg <= p_speed;
            heading_reg <= p_heading;
            accel_reg <= p_accel;
            rel_speed_reg <= p_rel_speed;
            rel_accel_reg <= p_rel_accel;
        end
    end

    assign out_valid = ov_reg;
    assign speed = speed_reg;
    assign heading = heading_reg;
    assign accel = accel_reg;
    assign rel_speed = rel_speed_reg;
    assign rel_accel = rel_accel_reg;
endmodule
`default_nettype wire

@@ rtl/core/vks_cell.sv @@
// One CORDIC vectoring micro-rotation cell of the chain.
`timescale 1ns / 1ps
`default_nettype none
module vks_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  vks_pkg::vks_data_t data_in,
    output logic               valid_out,
    output vks_pkg::vks_data_t data_out
);
    import vks_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  dz;
    vks_data_t              data_next;
    vks_data_t              data_reg;
    logic                   valid_reg;

    always_comb
    begin
        dx = data_in.y >>> STAGE;
        dy = data_in.x >>> STAGE;
        dz = $signed(ATAN_TAB[STAGE]);
        data_next = data_in;
        if (!data_in.y[XY_W-1])
        begin
            data_next.x = data_in.x + dx;
            data_next.y = data_in.y - dy;
            data_next.z = data_in.z + dz;
        end
        else
        begin
            data_next.x = data_in.x - dx;
            data_next.y = data_in.y + dy;
            data_next.z = data_in.z - dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out = data_reg;
endmodule
`default_nettype wire

@@ rtl/core/vks_post.sv @@
// Gain scaling, heading rounding and acceleration stages after the chain.
`timescale 1ns / 1ps
`default_nettype none
module vks_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  vks_pkg::vks_data_t data_in,
    output logic               valid_out,
    output logic [15:0]        speed,
    output logic signed [15:0] heading,
    output logic signed [10:0] accel,
    output logic signed [17:0] rel_speed,
    output logic signed [16:0] rel_accel
);
    import vks_pkg::*;

    logic [33:0]        xc;
    logic signed [Z_W:0] zr;
    logic signed [17:0] hs;
    logic signed [15:0] h_next;
    logic               v1_reg;
    logic [40:0]        ph_reg;
    logic [40:0]        pl_reg;
    logic signed [15:0] h1_reg;
    logic               zero1_reg;
    logic signed [15:0] ev1_reg;
    logic signed [15:0] ea1_reg;
    logic               st1_reg;

    logic [58:0]        prod;
    logic [18:0]        m;
    logic [15:0]        sp_next;
    logic               v2_reg;
    logic [15:0]        sp2_reg;
    logic signed [15:0] h2_reg;
    logic signed [15:0] ev2_reg;
    logic signed [15:0] ea2_reg;
    logic               st2_reg;

    logic signed [16:0] diff;
    logic               v3_reg;
    logic [15:0]        ad3_reg;
    logic               neg3_reg;
    logic               first3_reg;
    logic [15:0]        sp3_reg;
    logic signed [15:0] h3_reg;
    logic signed [15:0] ev3_reg;
    logic signed [15:0] ea3_reg;
    logic [15:0]        prev_speed_reg;
    logic               have_prev_reg;

    logic [32:0]        qp;
    logic [10:0]        q;
    logic signed [10:0] acc;

    always_comb
    begin
        xc = data_in.x[XY_W-1] ? 34'd0 : data_in.x[33:0];
        zr = {data_in.z[Z_W-1], data_in.z} + (Z_W+1)'(4096);
        hs = 18'(zr >>> 13);
        if (hs > HEADING_LIMIT)
        begin
            h_next = 16'(HEADING_LIMIT);
        end
        else if (hs < -HEADING_LIMIT)
        begin
            h_next = 16'(-HEADING_LIMIT);
        end
        else
        begin
            h_next = hs[15:0];
        end
        if (data_in.zero)
        begin
            h_next = 16'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg <= {24'd0, xc[33:17]} * {17'd0, GAIN_Q24};
        pl_reg <= {24'd0, xc[16:0]} * {17'd0, GAIN_Q24};
        h1_reg <= h_next;
        zero1_reg <= data_in.zero;
        ev1_reg <= data_in.ego_speed;
        ea1_reg <= data_in.ego_accel;
        st1_reg <= data_in.start;
    end

    always_comb
    begin
        prod = {ph_reg, 17'd0} + {18'd0, pl_reg} + (59'd1 << 39);
        m = prod[58:40];
        sp_next = (m > {3'd0, SPEED_MAX}) ? SPEED_MAX : m[15:0];
        if (zero1_reg)
        begin
            sp_next = 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        sp2_reg <= sp_next;
        h2_reg <= h1_reg;
        ev2_reg <= ev1_reg;
        ea2_reg <= ea1_reg;
        st2_reg <= st1_reg;
    end

    assign diff = $signed({1'b0, sp2_reg}) - $signed({1'b0, prev_speed_reg});

    always_ff @(posedge clk)
    begin
        neg3_reg <= diff[16];
        ad3_reg <= diff[16] ? 16'(-diff) : diff[15:0];
        first3_reg <= st2_reg || !have_prev_reg;
        sp3_reg <= sp2_reg;
        h3_reg <= h2_reg;
        ev3_reg <= ev2_reg;
        ea3_reg <= ea2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            prev_speed_reg <= 16'd0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v2_reg)
            begin
                prev_speed_reg <= sp2_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        qp = {1'b0, ad3_reg} * {16'd0, DIV50_RECIP};
        q = qp[32:22];
        acc = neg3_reg ? -$signed(q) : $signed(q);
        if (first3_reg)
        begin
            acc = 11'sd0;
        end
    end

    assign valid_out = v3_reg;
    assign speed = sp3_reg;
    assign heading = h3_reg;
    assign accel = acc;
    assign rel_speed = 18'(ev3_reg) - $signed({2'b00, sp3_reg});
    assign rel_accel = 17'(ea3_reg) - 17'(acc);
endmodule
`default_nettype wire

@@ sim/vks_checker.sv @@
// Checker that predicts vehicle kinematics results and compares them with the output beats.
`timescale 1ns / 1ps
module vks_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] long_speed,
    input  logic signed [15:0] lat_speed,
    input  logic signed [15:0] ego_speed,
    input  logic signed [15:0] ego_accel,
    input  logic               series_start,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        speed,
    input  logic signed [15:0] heading,
    input  logic signed [10:0] accel,
    input  logic signed [17:0] rel_speed,
    input  logic signed [16:0] rel_accel,
    output int                 errors,
    output int                 pending
);
    typedef struct packed {
        logic [15:0]        speed;
        logic signed [15:0] heading;
        logic signed [10:0] accel;
        logic signed [17:0] rel_speed;
        logic signed [16:0] rel_accel;
    } kin_t;

    longint atan_q20 [24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7};

    kin_t      kin_q[$];
    logic [15:0] last_speed;
    bit        seen_sample;

    function automatic kin_t predict_kinematics(longint lon, longint lat, longint ev,
                                                longint ea, bit start);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint mag;
        longint acc;
        int n;
        kin_t r;
        x = lon <<< 16;
        y = lat <<< 16;
        z = 0;
        mag = 0;
        acc = 0;
        if (lon != 0 || lat != 0)
        begin
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y; y = -t; z = 90 <<< 20;
                end
                else
                begin
                    x = -y; y = t; z = -(90 <<< 20);
                end
            end
            n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
            for (int i = 0; i < n; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += atan_q20[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= atan_q20[i];
                end
            end
            if (x < 0)
                x = 0;
            mag = (x * 10188014 + (longint'(1) <<< 39)) >>> 40;
            if (mag > 46341)
                mag = 46341;
            z = (z + 4096) >>> 13;
            if (z > 23040)
                z = 23040;
            if (z < -23040)
                z = -23040;
        end
        if (!start && seen_sample)
            acc = (mag - longint'(last_speed)) / 50;
        last_speed = mag[15:0];
        seen_sample = 1'b1;
        r.speed = mag[15:0];
        r.heading = z[15:0];
        r.accel = acc[10:0];
        r.rel_speed = 18'(ev - mag);
        r.rel_accel = 17'(ea - acc);
        return r;
    endfunction

    assign pending = kin_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        kin_t want;
        kin_t got;
        if (!rst_n)
        begin
            kin_q.delete();
            last_speed = '0;
            seen_sample = 1'b0;
            errors <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{speed, heading, accel, rel_speed, rel_accel};
                if (kin_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("Unexpected result beat: %p", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = kin_q.pop_front();
                    if (want !== got)
                    begin
                        if (errors < 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                kin_q.push_back(predict_kinematics(long_speed, lat_speed, ego_speed,
                                                   ego_accel, series_start));
        end
    end
endmodule

@@ sim/tb.sv @@
// Testbench top that drives the vehicle kinematics stream and reports the verdict.
`timescale 1ns / 1ps
module tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] long_speed;
    logic signed [15:0] lat_speed;
    logic signed [15:0] ego_speed;
    logic signed [15:0] ego_accel;
    logic               series_start;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        speed;
    logic signed [15:0] heading;
    logic signed [10:0] accel;
    logic signed [17:0] rel_speed;
    logic signed [16:0] rel_accel;
    int                 errors;
    int                 pending;
    int                 cycles;
    bit                 hold_off;
    bit                 calm;

    vehicle_kinematics_stream dut (.*);
    vks_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls in random bursts, with one long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    task automatic send_beat(logic signed [15:0] lon, logic signed [15:0] lat,
                             logic signed [15:0] ev, logic signed [15:0] ea, logic st);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        long_speed <= lon;
        lat_speed <= lat;
        ego_speed <= ev;
        ego_accel <= ea;
        series_start <= st;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] vals [8] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff,
                                  16'h0001, 16'h0100, 16'hff00, 16'h1234};
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        long_speed = '0;
        lat_speed = '0;
        ego_speed = '0;
        ego_accel = '0;
        series_start = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_beat(-16'sd256, 16'sd0, 16'sh7fff, 16'sh8000, 1'b0);
        send_beat(-16'sd256, -16'sd1, 16'sh8000, 16'sh7fff, 1'b0);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_beat(vals[i], vals[7 - i], vals[(i + 3) % 8], vals[(i + 5) % 8], i[0]);
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++)
            send_beat(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < 480; i++)
        begin
            if (i == 400)
                calm = 1'b1;
            send_beat(rand_word(), rand_word(), rand_word(), rand_word(),
                      $urandom_range(0, 7) == 0);
        end
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ vehicle_kinematics_stream.f @@
rtl/core/vks_pkg.sv
rtl/core/vks_cell.sv
rtl/core/vks_post.sv
rtl/core/vehicle_kinematics_stream.sv
sim/vks_checker.sv
sim/tb.sv
